>>> hdl/gre_pkg.sv
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types and codes for the graph reachability engine: request and
// result items, command and status codes, controller states and the
// controller to datapath control bundles.
// ----------------------------------------------------------------------------
package gre_pkg;

    // request item
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] src_label;
        logic [7:0] dst_label;
    } t_in_item;

    // result item
    typedef struct packed {
        logic       path_found;
        logic [1:0] status;
    } t_out_item;

    // request command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_WR_SRC,
        S_WR_DST,
        S_ROW_RD,
        S_ROW_WR,
        S_REACH_LD,
        S_SWEEP,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       clear;
        logic       scan_start;
        logic       scan_en;
        logic       wr_src;
        logic       wr_dst;
        logic       row_rd;
        logic       row_wr;
        logic       reach_ld;
        logic       sweep_start;
        logic       sweep_en;
        logic       res_load;
        logic       res_path;
        logic [1:0] res_status;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic walk_done;
        logic src_hit;
        logic dst_hit;
        logic same_label;
        logic table_full;
        logic reach_chg;
    } t_dp_sts;

endpackage

>>> hdl/gre_ram.sv
// ----------------------------------------------------------------------------
// gre_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module gre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/gre_dp.sv
// ----------------------------------------------------------------------------
// gre_dp
// Datapath: label table and adjacency memories, label scan, edge insertion,
// reachability sweeps and the result register.
// ----------------------------------------------------------------------------
module gre_dp #(
    parameter int MAX_NODES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gre_pkg::t_in_item i_in,
    input  gre_pkg::t_dp_cmd  i_cmd,
    output gre_pkg::t_dp_sts  o_sts,
    output gre_pkg::t_out_item o_out
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    // control state
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_ptr;
    logic                 r_cmp_vld;
    logic                 r_src_hit;
    logic                 r_dst_hit;
    logic                 r_chg;
    logic                 r_rdv;
    logic [MAX_NODES-1:0] r_row_vld;
    logic [MAX_NODES-1:0] r_reach;

    // payload state
    logic [7:0]          r_src;
    logic [7:0]          r_dst;
    logic [IW-1:0]       r_si;
    logic [IW-1:0]       r_di;
    logic [IW-1:0]       r_cmp_idx;
    gre_pkg::t_out_item  r_out;

    logic [7:0]           lab_q;
    logic [7:0]           lab_wdata;
    logic                 lab_we;
    logic [MAX_NODES-1:0] adj_q;
    logic [MAX_NODES-1:0] row_q;
    logic [MAX_NODES-1:0] onehot;
    logic [IW-1:0]        adj_raddr;
    logic                 issue;
    logic                 walk_en;
    logic                 same;
    logic [1:0]           need;
    logic [CW:0]          need_sum;

    // memory addressing
    assign issue     = r_ptr < r_count;
    assign walk_en   = i_cmd.scan_en | i_cmd.sweep_en;
    assign lab_we    = i_cmd.wr_src | i_cmd.wr_dst;
    assign lab_wdata = i_cmd.wr_src ? r_src : r_dst;
    assign adj_raddr = i_cmd.row_rd ? r_si : r_ptr[IW-1:0];
    assign row_q     = r_rdv ? adj_q : '0;
    assign onehot    = {{(MAX_NODES-1){1'b0}}, 1'b1} << r_di;

    gre_ram #(
        .WIDTH(8),
        .DEPTH(MAX_NODES)
    ) u_label_ram (
        .i_clk  (i_clk),
        .i_we   (lab_we),
        .i_waddr(r_count[IW-1:0]),
        .i_wdata(lab_wdata),
        .i_raddr(r_ptr[IW-1:0]),
        .o_rdata(lab_q)
    );

    gre_ram #(
        .WIDTH(MAX_NODES),
        .DEPTH(MAX_NODES)
    ) u_adj_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.row_wr),
        .i_waddr(r_si),
        .i_wdata(row_q | onehot),
        .i_raddr(adj_raddr),
        .o_rdata(adj_q)
    );

    // free index check for an edge insertion
    assign same     = r_src == r_dst;
    assign need     = {1'b0, ~r_src_hit} + {1'b0, ~r_dst_hit & ~(~r_src_hit & same)};
    assign need_sum = {1'b0, r_count} + (CW+1)'(need);

    // status to controller
    always_comb begin
        o_sts.walk_done  = (r_ptr == r_count) && !r_cmp_vld;
        o_sts.src_hit    = r_src_hit;
        o_sts.dst_hit    = r_dst_hit;
        o_sts.same_label = same;
        o_sts.table_full = need_sum > (CW+1)'(MAX_NODES);
        o_sts.reach_chg  = r_chg;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
            r_src_hit <= 1'b0;
            r_dst_hit <= 1'b0;
            r_chg     <= 1'b0;
            r_rdv     <= 1'b0;
            r_row_vld <= '0;
            r_reach   <= '0;
        end else begin
            r_rdv <= r_row_vld[adj_raddr];
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_row_vld <= '0;
                r_reach   <= '0;
            end
            if (i_cmd.scan_start) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
                r_src_hit <= 1'b0;
                r_dst_hit <= 1'b0;
            end
            if (i_cmd.sweep_start) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
                r_chg     <= 1'b0;
            end
            // walk pointer and read pipeline
            if (walk_en) begin
                if (issue) begin
                    r_ptr <= r_ptr + CW'(1);
                end
                r_cmp_vld <= issue;
            end
            // label compare stage
            if (i_cmd.scan_en && r_cmp_vld) begin
                if (lab_q == r_src) begin
                    r_src_hit <= 1'b1;
                end
                if (lab_q == r_dst) begin
                    r_dst_hit <= 1'b1;
                end
            end
            if (i_cmd.wr_src || i_cmd.wr_dst) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.row_wr) begin
                r_row_vld[r_si] <= 1'b1;
            end
            if (i_cmd.reach_ld) begin
                r_reach <= row_q;
            end
            // fold in the row of a reached node
            if (i_cmd.sweep_en && r_cmp_vld && r_reach[r_cmp_idx]) begin
                r_reach <= r_reach | row_q;
                if ((row_q & ~r_reach) != '0) begin
                    r_chg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_src <= i_in.src_label;
            r_dst <= i_in.dst_label;
        end
        if (walk_en && issue) begin
            r_cmp_idx <= r_ptr[IW-1:0];
        end
        if (i_cmd.scan_en && r_cmp_vld) begin
            if (lab_q == r_src) begin
                r_si <= r_cmp_idx;
            end
            if (lab_q == r_dst) begin
                r_di <= r_cmp_idx;
            end
        end
        // new label indices
        if (i_cmd.wr_src) begin
            r_si <= r_count[IW-1:0];
            if (!r_dst_hit && same) begin
                r_di <= r_count[IW-1:0];
            end
        end
        if (i_cmd.wr_dst) begin
            r_di <= r_count[IW-1:0];
        end
        if (i_cmd.res_load) begin
            r_out.path_found <= i_cmd.res_path & r_reach[r_di];
            r_out.status     <= i_cmd.res_status;
        end
    end

    assign o_out = r_out;

endmodule

>>> hdl/gre_ctrl.sv
// ----------------------------------------------------------------------------
// gre_ctrl
// Controller: sequences the label scan, edge insertion and reachability
// sweeps, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module gre_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gre_pkg::t_dp_cmd o_cmd,
    input  gre_pkg::t_dp_sts i_sts
);

    gre_pkg::t_state r_state;
    gre_pkg::t_state n_state;
    logic            r_is_query;
    logic            n_is_query;
    logic [1:0]      r_res_st;
    logic [1:0]      n_res_st;
    logic            r_res_path;
    logic            n_res_path;
    logic            r_out_vld;
    logic            n_out_vld;
    logic            accept;
    logic            res_free;

    assign accept   = i_in_valid && (r_state == gre_pkg::S_IDLE);
    assign res_free = !r_out_vld || i_out_ready;

    // next state
    always_comb begin
        n_state    = r_state;
        n_is_query = r_is_query;
        n_res_st   = r_res_st;
        n_res_path = r_res_path;
        unique case (r_state)
            gre_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_st   = gre_pkg::ST_OK;
                    n_res_path = 1'b0;
                    unique case (i_in_cmd)
                        gre_pkg::CMD_ADD: begin
                            n_is_query = 1'b0;
                            n_state    = gre_pkg::S_SCAN;
                        end
                        gre_pkg::CMD_QUERY: begin
                            n_is_query = 1'b1;
                            n_state    = gre_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = gre_pkg::S_DONE;
                        end
                    endcase
                end
            end
            gre_pkg::S_SCAN: begin
                if (i_sts.walk_done) begin
                    if (r_is_query) begin
                        if (i_sts.src_hit && i_sts.dst_hit) begin
                            n_state = gre_pkg::S_ROW_RD;
                        end else begin
                            n_res_st = gre_pkg::ST_UNKNOWN;
                            n_state  = gre_pkg::S_DONE;
                        end
                    end else if (i_sts.table_full) begin
                        n_res_st = gre_pkg::ST_FULL;
                        n_state  = gre_pkg::S_DONE;
                    end else if (!i_sts.src_hit) begin
                        n_state = gre_pkg::S_WR_SRC;
                    end else if (!i_sts.dst_hit) begin
                        n_state = gre_pkg::S_WR_DST;
                    end else begin
                        n_state = gre_pkg::S_ROW_RD;
                    end
                end
            end
            gre_pkg::S_WR_SRC: begin
                if (!i_sts.dst_hit && !i_sts.same_label) begin
                    n_state = gre_pkg::S_WR_DST;
                end else begin
                    n_state = gre_pkg::S_ROW_RD;
                end
            end
            gre_pkg::S_WR_DST: begin
                n_state = gre_pkg::S_ROW_RD;
            end
            gre_pkg::S_ROW_RD: begin
                n_state = r_is_query ? gre_pkg::S_REACH_LD : gre_pkg::S_ROW_WR;
            end
            gre_pkg::S_ROW_WR: begin
                n_state = gre_pkg::S_DONE;
            end
            gre_pkg::S_REACH_LD: begin
                n_state = gre_pkg::S_SWEEP;
            end
            gre_pkg::S_SWEEP: begin
                if (i_sts.walk_done && !i_sts.reach_chg) begin
                    n_res_path = 1'b1;
                    n_state    = gre_pkg::S_DONE;
                end
            end
            gre_pkg::S_DONE: begin
                if (res_free) begin
                    n_state = gre_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gre_pkg::S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = r_res_st;
        o_cmd.res_path   = r_res_path;
        unique case (r_state)
            gre_pkg::S_IDLE: begin
                o_cmd.load_in    = accept;
                o_cmd.scan_start = accept;
                o_cmd.clear      = accept && (i_in_cmd == gre_pkg::CMD_CLEAR);
            end
            gre_pkg::S_SCAN: begin
                o_cmd.scan_en = 1'b1;
            end
            gre_pkg::S_WR_SRC: begin
                o_cmd.wr_src = 1'b1;
            end
            gre_pkg::S_WR_DST: begin
                o_cmd.wr_dst = 1'b1;
            end
            gre_pkg::S_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
            end
            gre_pkg::S_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
            end
            gre_pkg::S_REACH_LD: begin
                o_cmd.reach_ld    = 1'b1;
                o_cmd.sweep_start = 1'b1;
            end
            gre_pkg::S_SWEEP: begin
                if (i_sts.walk_done) begin
                    o_cmd.sweep_start = i_sts.reach_chg;
                end else begin
                    o_cmd.sweep_en = 1'b1;
                end
            end
            gre_pkg::S_DONE: begin
                o_cmd.res_load = res_free;
            end
            default: begin
                o_cmd.res_load = 1'b0;
            end
        endcase
    end

    // result valid
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.res_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gre_pkg::S_IDLE;
            r_is_query <= 1'b0;
            r_res_st   <= gre_pkg::ST_OK;
            r_res_path <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_is_query <= n_is_query;
            r_res_st   <= n_res_st;
            r_res_path <= n_res_path;
            r_out_vld  <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == gre_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

>>> hdl/graph_reachability_engine_core.sv
// ----------------------------------------------------------------------------
// Clear and unused commands go straight from request accept to the result.
// Add and query first scan the assigned labels; add edge then writes any new
// labels and the row, while a full table or unknown query label goes to the result.
// Query: after the scan, closure sweeps repeat until the reach set stops growing.
// Throughput: one request at a time; a new request is taken while a result waits.
// Reset (synchronous, active low) empties the graph at once, no sweep needed.
// ----------------------------------------------------------------------------
// graph_reachability_engine_core
// Directed graph over 8-bit labelled nodes with reachability queries.
// ----------------------------------------------------------------------------
module graph_reachability_engine_core #(
    parameter int MAX_NODES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gre_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gre_pkg::t_out_item o_out_data
);

    gre_pkg::t_dp_cmd dp_cmd;
    gre_pkg::t_dp_sts dp_sts;

    // sequencing
    gre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    // storage and compute
    gre_dp #(
        .MAX_NODES(MAX_NODES)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in_data),
        .i_cmd  (dp_cmd),
        .o_sts  (dp_sts),
        .o_out  (o_out_data)
    );

endmodule

>>> hdl/gre_chk.sv
// ----------------------------------------------------------------------------
// gre_chk
// Port level checks for the graph reachability engine, bound to the top.
// ----------------------------------------------------------------------------
module gre_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input gre_pkg::t_out_item o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // one request at a time: ready drops after a request is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == gre_pkg::ST_OK ||
                         o_out_data.status == gre_pkg::ST_FULL ||
                         o_out_data.status == gre_pkg::ST_UNKNOWN))
        else $error("undefined status code");

    // a found path comes only with ok status
    a_path_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.path_found |-> o_out_data.status == gre_pkg::ST_OK)
        else $error("path reported with error status");

    // nothing to deliver right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind graph_reachability_engine_core gre_chk u_gre_chk (.*);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for graph_reachability_engine_core. A short directed
// run covers the label extremes, self loops, unknown labels, a full label
// table, clears and the unused command. Random phases then build graphs from
// small label pools and query them, under varying sender and receiver idling.
// Each request is predicted on acceptance and each result is checked in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_NODES = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 475;
    localparam int TAIL_CYCLES = 400;

    // tracks the graph and the results it should produce
    class reach_tracker;
        logic [7:0]           node_label [MAX_NODES];
        int                   node_count;
        logic [MAX_NODES-1:0] adj_row [MAX_NODES];
        logic [MAX_NODES-1:0] last_reach;
        gre_pkg::t_out_item   pending_results [$];
        int                   mismatches;

        function new();
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            node_count = 0;
            for (int i = 0; i < MAX_NODES; i++) begin
                adj_row[i] = '0;
            end
            last_reach = '0;
        endfunction

        function int find_node(logic [7:0] lab);
            for (int i = 0; i < node_count; i++) begin
                if (node_label[i] == lab) return i;
            end
            return -1;
        endfunction

        // nodes reachable by one or more edges, bounded rounds of row merging
        function logic [MAX_NODES-1:0] reach_from(int node);
            logic [MAX_NODES-1:0] reach;
            logic [MAX_NODES-1:0] grown;
            reach = adj_row[node];
            for (int r = 0; r < MAX_NODES; r++) begin
                grown = reach;
                for (int i = 0; i < node_count; i++) begin
                    if (reach[i]) grown |= adj_row[i];
                end
                reach = grown;
            end
            return reach;
        endfunction

        // update the graph for an accepted request and queue its result
        function void note_request(gre_pkg::t_in_item req);
            gre_pkg::t_out_item exp;
            int                 si;
            int                 di;
            int                 need;
            exp.path_found = 1'b0;
            exp.status     = gre_pkg::ST_OK;
            si = find_node(req.src_label);
            di = find_node(req.dst_label);
            case (req.cmd)
                gre_pkg::CMD_ADD: begin
                    need = 0;
                    if (si < 0) need++;
                    if (di < 0 && !(si < 0 && req.src_label == req.dst_label)) need++;
                    if (node_count + need > MAX_NODES) begin
                        exp.status = gre_pkg::ST_FULL;
                    end else begin
                        if (si < 0) begin
                            node_label[node_count] = req.src_label;
                            si = node_count;
                            node_count++;
                        end
                        if (di < 0) begin
                            if (req.src_label == req.dst_label) begin
                                di = si;
                            end else begin
                                node_label[node_count] = req.dst_label;
                                di = node_count;
                                node_count++;
                            end
                        end
                        adj_row[si][di] = 1'b1;
                    end
                end
                gre_pkg::CMD_QUERY: begin
                    if (si < 0 || di < 0) begin
                        exp.status = gre_pkg::ST_UNKNOWN;
                    end else begin
                        last_reach     = reach_from(si);
                        exp.path_found = last_reach[di];
                    end
                end
                gre_pkg::CMD_CLEAR: begin
                    wipe();
                end
                default: begin
                end
            endcase
            pending_results.insert(pending_results.size(), exp);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
        endfunction

        // compare an accepted result against the oldest prediction
        function void check_result(gre_pkg::t_out_item got);
            gre_pkg::t_out_item exp;
            if (pending_results.size() == 0) begin
                flag($sformatf("unexpected result path_found=%b status=%0d",
                               got.path_found, got.status));
                return;
            end
            exp = pending_results.pop_front();
            if (got.path_found !== exp.path_found)
                flag($sformatf("path_found exp %b got %b", exp.path_found, got.path_found));
            if (got.status !== exp.status)
                flag($sformatf("status exp %0d got %0d", exp.status, got.status));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    gre_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    gre_pkg::t_out_item out_data;

    int send_idle;
    int recv_stall;

    reach_tracker sb;

    graph_reachability_engine_core #(
        .MAX_NODES(MAX_NODES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #30000000;
        $display("tb: errors");
        $finish;
    end

    // receiver stalls
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            sb.check_result(out_data);
        end
    end

    function automatic gre_pkg::t_in_item mk_request(logic [1:0] c, logic [7:0] s,
                                                     logic [7:0] d);
        gre_pkg::t_in_item r;
        r.cmd       = c;
        r.src_label = s;
        r.dst_label = d;
        return r;
    endfunction

    // drive one request, with random idle cycles ahead of it
    task automatic push_request(gre_pkg::t_in_item req);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        sb.note_request(req);
    endtask

    // hold off the sender until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // extremes, self loops, unknown labels, unused command, full table
    task automatic directed_seq();
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h00, 8'hFF));
        push_request(mk_request(gre_pkg::CMD_ADD, 8'h00, 8'hFF));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h00, 8'hFF));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'hFF, 8'h00));
        push_request(mk_request(gre_pkg::CMD_ADD, 8'h5A, 8'h5A));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h5A, 8'h5A));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h00, 8'h00));
        push_request(mk_request(gre_pkg::CMD_ADD, 8'hFF, 8'h00));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h00, 8'h00));
        push_request(mk_request(CMD_UNUSED, 8'hA5, 8'h5A));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h00, 8'h77));
        push_request(mk_request(gre_pkg::CMD_CLEAR, 8'hFF, 8'hFF));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h00, 8'hFF));
        // fill the table to fifteen labels
        for (int k = 0; k < 7; k++) begin
            push_request(mk_request(gre_pkg::CMD_ADD, 8'h10 + 8'(2 * k),
                                    8'h11 + 8'(2 * k)));
        end
        push_request(mk_request(gre_pkg::CMD_ADD, 8'h30, 8'h30));
        // two new labels, one slot left
        push_request(mk_request(gre_pkg::CMD_ADD, 8'h31, 8'h32));
        push_request(mk_request(gre_pkg::CMD_ADD, 8'h10, 8'h33));
        // one new label, table full
        push_request(mk_request(gre_pkg::CMD_ADD, 8'h34, 8'h10));
        push_request(mk_request(gre_pkg::CMD_QUERY, 8'h10, 8'h33));
    endtask

    // graphs built from small label pools, mixed with noise
    task automatic run_random(int n);
        logic [7:0] pool [$];
        logic [1:0] c;
        logic [7:0] s;
        logic [7:0] d;
        int         roll;
        int         a;
        int         b;
        int         psize;
        for (int k = 0; k < n; k++) begin
            if (pool.size() == 0) begin
                psize = $urandom_range(20, 4);
                for (int j = 0; j < psize; j++) begin
                    pool.insert(pool.size(), 8'($urandom_range(255)));
                end
            end
            roll = $urandom_range(99);
            a = $urandom_range(pool.size() - 1);
            b = $urandom_range(1) ? (a + 1) % pool.size() : $urandom_range(pool.size() - 1);
            s = pool[a];
            d = pool[b];
            if (roll < 2) begin
                c = gre_pkg::CMD_CLEAR;
                pool.delete();
            end else if (roll < 47) begin
                c = gre_pkg::CMD_ADD;
            end else if (roll < 87) begin
                c = gre_pkg::CMD_QUERY;
            end else begin
                c = 2'($urandom_range(3));
                s = 8'($urandom_range(255));
                d = 8'($urandom_range(255));
            end
            push_request(mk_request(c, s, d));
        end
    endtask

    // main sequence
    initial begin
        sb         = new();
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        send_idle  = 0;
        recv_stall = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_seq();
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
